### design/afc_pkg.sv
// afc_pkg: shared types, widths, register indexes and lane helpers
// for the AABB frustum culling block. No dependencies.

package afc_pkg;

    // Default lane width in use (bits per Q8.8 entry actually read)
    localparam int COEF_BITS_DEF = 16;

    // Packing of matrix rows and box vectors
    localparam int LANE_W   = 16;
    localparam int ROW_W    = 4 * LANE_W;
    localparam int VEC_W    = 3 * LANE_W;

    // Arithmetic widths (all full precision)
    localparam int PLANE_W  = LANE_W + 1;            // sum of two entries
    localparam int PROD_W   = 2 * LANE_W;            // entry times coordinate
    localparam int CORNER_W = PROD_W + 2;            // three products plus w term
    localparam int DPROD_W  = PLANE_W + CORNER_W;    // plane times corner
    localparam int DOT_W    = DPROD_W + 2;           // sum of four

    localparam int N_CORNER = 8;
    localparam int N_PLANE  = 6;

    // Local w = 1.0 in Q8.8 is a left shift by this amount
    localparam int W_ONE_SHIFT = 8;

    // Configuration register indexes
    localparam int CFG_IDX_W = 4;
    localparam logic [CFG_IDX_W-1:0] REG_VP_ROW0 = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VP_ROW1 = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VP_ROW2 = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VP_ROW3 = 4'd3;

    typedef logic signed [LANE_W-1:0]   lane_t;
    typedef logic signed [PLANE_W-1:0]  plane_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [CORNER_W-1:0] corner_t;
    typedef logic signed [DPROD_W-1:0]  dprod_t;
    typedef logic signed [DOT_W-1:0]    dot_t;

    // Take lane idx of a packed word, keep the low cb bits and sign-extend
    // from bit cb-1 to the full lane width.
    function automatic lane_t lane_ext(input logic [ROW_W-1:0] word,
                                       input int idx, input int cb);
        lane_t res;
        for (int b = 0; b < LANE_W; b++) begin
            if (b < cb)
                res[b] = word[idx*LANE_W + b];
            else
                res[b] = word[idx*LANE_W + cb - 1];
        end
        return res;
    endfunction

endpackage

### design/afc_corner_xform.sv
// afc_corner_xform: two-stage transform of the 8 box corners by the
// model matrix. Depends on afc_pkg.

module afc_corner_xform
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  afc_pkg::lane_t    m      [4][4],
    input  afc_pkg::lane_t    lo     [3],
    input  afc_pkg::lane_t    hi     [3],
    output logic              out_valid,
    output afc_pkg::corner_t  corner [afc_pkg::N_CORNER][4]
);

    afc_pkg::prod_t   plo_reg [4][3];
    afc_pkg::prod_t   phi_reg [4][3];
    afc_pkg::lane_t   mw_reg  [4];
    afc_pkg::corner_t corner_reg [afc_pkg::N_CORNER][4];
    afc_pkg::corner_t corner_next [afc_pkg::N_CORNER][4];
    logic             v1_reg;
    logic             v2_reg;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    // Stage 1: entry times min and max coordinate per axis
    always_ff @(posedge clk)
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                plo_reg[r][c] <= m[r][c] * lo[c];
                phi_reg[r][c] <= m[r][c] * hi[c];
            end
            mw_reg[r] <= m[r][3];
        end
    end

    // Stage 2: pick min or max product per axis, add the w column
    always_comb
    begin
        for (int p = 0; p < afc_pkg::N_CORNER; p++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                corner_next[p][r] =
                    {{(afc_pkg::CORNER_W-afc_pkg::LANE_W-afc_pkg::W_ONE_SHIFT)
                      {mw_reg[r][afc_pkg::LANE_W-1]}},
                     mw_reg[r], {afc_pkg::W_ONE_SHIFT{1'b0}}};
                for (int c = 0; c < 3; c++)
                begin
                    if (p[c])
                        corner_next[p][r] = corner_next[p][r] +
                            {{2{phi_reg[r][c][afc_pkg::PROD_W-1]}}, phi_reg[r][c]};
                    else
                        corner_next[p][r] = corner_next[p][r] +
                            {{2{plo_reg[r][c][afc_pkg::PROD_W-1]}}, plo_reg[r][c]};
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        corner_reg <= corner_next;
    end

    assign out_valid = v2_reg;
    assign corner    = corner_reg;

endmodule

### design/aabb_frustum_cull.sv
// aabb_frustum_cull: top level, config registers, plane derivation and
// plane tests. Depends on afc_pkg and afc_corner_xform.
//
// One item per cycle, no stalls. The path is six register stages: input
// lanes, corner products, corner sums, plane products, dot-product signs,
// per-plane reduction. busy never rises and cfg_ready is always high.
// Reset clears the view-projection rows to zero, so all planes are zero
// and every item reads visible until the rows are written.

module aabb_frustum_cull
#(
    parameter int COEF_BITS = afc_pkg::COEF_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [afc_pkg::ROW_W-1:0]      model_row0,
    input  logic [afc_pkg::ROW_W-1:0]      model_row1,
    input  logic [afc_pkg::ROW_W-1:0]      model_row2,
    input  logic [afc_pkg::ROW_W-1:0]      model_row3,
    input  logic [afc_pkg::VEC_W-1:0]      box_min,
    input  logic [afc_pkg::VEC_W-1:0]      box_max,
    output logic                           done,
    output logic                           visible,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::ROW_W-1:0]      cfg_data
);

    logic [afc_pkg::ROW_W-1:0] vp_reg [4];
    afc_pkg::plane_t  plane_reg [afc_pkg::N_PLANE][4];
    afc_pkg::lane_t   m_reg  [4][4];
    afc_pkg::lane_t   lo_reg [3];
    afc_pkg::lane_t   hi_reg [3];
    logic             v0_reg;
    logic             cx_valid;
    afc_pkg::corner_t corner [afc_pkg::N_CORNER][4];
    afc_pkg::dprod_t  dprod_reg [afc_pkg::N_PLANE][afc_pkg::N_CORNER][4];
    logic             v3_reg;
    logic [afc_pkg::N_CORNER-1:0] out_reg [afc_pkg::N_PLANE];
    logic [afc_pkg::N_CORNER-1:0] out_next [afc_pkg::N_PLANE];
    logic             v4_reg;
    logic             vis_reg;
    logic             vis_next;
    logic             done_reg;
    logic             accept;
    logic             plane_zero;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                vp_reg[r] <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                afc_pkg::REG_VP_ROW0: vp_reg[0] <= cfg_data;
                afc_pkg::REG_VP_ROW1: vp_reg[1] <= cfg_data;
                afc_pkg::REG_VP_ROW2: vp_reg[2] <= cfg_data;
                afc_pkg::REG_VP_ROW3: vp_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Planes: row3 plus and minus rows 0..2, registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < afc_pkg::N_PLANE; k++)
                for (int c = 0; c < 4; c++)
                    plane_reg[k][c] <= '0;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    plane_reg[2*k][c] <=
                        afc_pkg::plane_t'(afc_pkg::lane_ext(vp_reg[3], c, COEF_BITS)) +
                        afc_pkg::plane_t'(afc_pkg::lane_ext(vp_reg[k], c, COEF_BITS));
                    plane_reg[2*k+1][c] <=
                        afc_pkg::plane_t'(afc_pkg::lane_ext(vp_reg[3], c, COEF_BITS)) -
                        afc_pkg::plane_t'(afc_pkg::lane_ext(vp_reg[k], c, COEF_BITS));
                end
            end
        end
    end

    // Valid bits of the top-level stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v0_reg   <= accept;
            v3_reg   <= cx_valid;
            v4_reg   <= v3_reg;
            done_reg <= v4_reg;
        end
    end

    // Stage 0: capture item, unpack lanes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int c = 0; c < 4; c++)
            begin
                m_reg[0][c] <= afc_pkg::lane_ext(model_row0, c, COEF_BITS);
                m_reg[1][c] <= afc_pkg::lane_ext(model_row1, c, COEF_BITS);
                m_reg[2][c] <= afc_pkg::lane_ext(model_row2, c, COEF_BITS);
                m_reg[3][c] <= afc_pkg::lane_ext(model_row3, c, COEF_BITS);
            end
            for (int k = 0; k < 3; k++)
            begin
                lo_reg[k] <= afc_pkg::lane_ext({16'b0, box_min}, k, COEF_BITS);
                hi_reg[k] <= afc_pkg::lane_ext({16'b0, box_max}, k, COEF_BITS);
            end
        end
    end

    // Stages 1-2: corner transform
    afc_corner_xform u_xform
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .m         (m_reg),
        .lo        (lo_reg),
        .hi        (hi_reg),
        .out_valid (cx_valid),
        .corner    (corner)
    );

    // Stage 3: plane coefficient times corner component
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < afc_pkg::N_PLANE; k++)
            for (int p = 0; p < afc_pkg::N_CORNER; p++)
                for (int c = 0; c < 4; c++)
                    dprod_reg[k][p][c] <= plane_reg[k][c] * corner[p][c];
    end

    // Stage 4: dot product sign; negative means outside, zero is inside
    always_comb
    begin
        afc_pkg::dot_t d;
        for (int k = 0; k < afc_pkg::N_PLANE; k++)
        begin
            for (int p = 0; p < afc_pkg::N_CORNER; p++)
            begin
                d = '0;
                for (int c = 0; c < 4; c++)
                    d = d + {{2{dprod_reg[k][p][c][afc_pkg::DPROD_W-1]}},
                             dprod_reg[k][p][c]};
                out_next[k][p] = d[afc_pkg::DOT_W-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    // Stage 5: culled if any plane has every corner outside
    always_comb
    begin
        vis_next = 1'b1;
        for (int k = 0; k < afc_pkg::N_PLANE; k++)
            if (&out_reg[k])
                vis_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        vis_reg <= vis_next;
    end

    assign done    = done_reg;
    assign visible = vis_reg;

    // Checks
    always_comb
    begin
        plane_zero = 1'b1;
        for (int k = 0; k < afc_pkg::N_PLANE; k++)
            for (int c = 0; c < 4; c++)
                if (plane_reg[k][c] != '0)
                    plane_zero = 1'b0;
    end

    // A result always stems from an earlier accepted item
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 6))
        else $error("result without a matching accepted item");

    // An accepted item always yields a result
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##6 done)
        else $error("accepted item lost in the pipeline");

    // All-zero planes give zero dot products, which never cull
    assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(plane_zero, 3) |-> visible)
        else $error("object culled by zero planes");

endmodule

### sim/afc_checker.sv
// afc_checker: watches the item, result and register-write channels of
// aabb_frustum_cull, predicts each visible bit and compares it in order.
// Depends on afc_pkg for widths and register indexes.

module afc_checker
#(
    parameter int COEF_BITS = afc_pkg::COEF_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [afc_pkg::ROW_W-1:0]      model_row0,
    input  logic [afc_pkg::ROW_W-1:0]      model_row1,
    input  logic [afc_pkg::ROW_W-1:0]      model_row2,
    input  logic [afc_pkg::ROW_W-1:0]      model_row3,
    input  logic [afc_pkg::VEC_W-1:0]      box_min,
    input  logic [afc_pkg::VEC_W-1:0]      box_max,
    input  logic                           done,
    input  logic                           visible,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [afc_pkg::ROW_W-1:0]      cfg_data,
    output int                             fail_cnt,
    output int                             pending,
    output int                             n_visible,
    output int                             n_culled
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [afc_pkg::ROW_W-1:0] vp_row [4];
    logic                      vis_q [$];

    // One Q8.8 lane, low COEF_BITS bits, sign-extended
    function automatic longint coef(input logic [afc_pkg::ROW_W-1:0] word, input int idx);
        logic [afc_pkg::LANE_W-1:0] raw;
        longint                     s;
        raw = word[idx*afc_pkg::LANE_W +: afc_pkg::LANE_W];
        s = longint'(raw) & ((longint'(1) << COEF_BITS) - 1);
        if (raw[COEF_BITS-1])
            s -= longint'(1) << COEF_BITS;
        return s;
    endfunction

    // Box is visible unless some plane has all eight transformed corners behind it
    function automatic logic box_in_frustum(input logic [afc_pkg::ROW_W-1:0] m [4],
                                            input logic [afc_pkg::VEC_W-1:0] bmin,
                                            input logic [afc_pkg::VEC_W-1:0] bmax);
        longint plane [6][4];
        longint corner [8][4];
        longint loc [4];
        longint d;
        logic   all_out;
        logic   vis;
        vis = 1'b1;
        for (int k = 0; k < 3; k++)
            for (int c = 0; c < 4; c++)
            begin
                plane[2*k][c]   = coef(vp_row[3], c) + coef(vp_row[k], c);
                plane[2*k+1][c] = coef(vp_row[3], c) - coef(vp_row[k], c);
            end
        for (int p = 0; p < afc_pkg::N_CORNER; p++)
        begin
            for (int a = 0; a < 3; a++)
                loc[a] = p[a] ? coef(64'(bmax), a) : coef(64'(bmin), a);
            loc[3] = 256;
            for (int r = 0; r < 4; r++)
            begin
                corner[p][r] = 0;
                for (int c = 0; c < 4; c++)
                    corner[p][r] += coef(m[r], c) * loc[c];
            end
        end
        for (int k = 0; k < afc_pkg::N_PLANE; k++)
        begin
            all_out = 1'b1;
            for (int p = 0; p < afc_pkg::N_CORNER; p++)
            begin
                d = 0;
                for (int c = 0; c < 4; c++)
                    d += plane[k][c] * corner[p][c];
                if (d >= 0)
                    all_out = 1'b0;
            end
            if (all_out)
                vis = 1'b0;
        end
        return vis;
    endfunction

    // Track registers, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        logic [afc_pkg::ROW_W-1:0] m [4];
        logic                      exp_vis;
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                vp_row[r] = '0;
            vis_q.delete();
            fail_cnt  = 0;
            pending   = 0;
            n_visible = 0;
            n_culled  = 0;
        end
        else
        begin
            if (done)
            begin
                if (vis_q.size() == 0)
                begin
                    $display("%0t: result with no item outstanding, visible %0b",
                             $time, visible);
                    fail_cnt++;
                end
                else
                begin
                    exp_vis = vis_q.pop_front();
                    if (visible !== exp_vis)
                    begin
                        $display("%0t: visible mismatch: expected %0b actual %0b",
                                 $time, exp_vis, visible);
                        fail_cnt++;
                    end
                    if (exp_vis)
                        n_visible++;
                    else
                        n_culled++;
                end
            end
            if (start && !busy)
            begin
                m[0] = model_row0;
                m[1] = model_row1;
                m[2] = model_row2;
                m[3] = model_row3;
                vis_q.push_back(box_in_frustum(m, box_min, box_max));
            end
            if (cfg_valid && cfg_ready && cfg_index <= afc_pkg::REG_VP_ROW3)
                vp_row[cfg_index[1:0]] = cfg_data;
            pending = vis_q.size();
        end
    end

endmodule

### sim/aabb_frustum_cull_tb.sv
// aabb_frustum_cull_tb: clock, reset and stimulus for aabb_frustum_cull;
// checking is done by afc_checker. Depends on afc_pkg, the block and afc_checker.

module aabb_frustum_cull_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT   = 5000;
    localparam int RAND_ITEMS = 1400;

    // Q8.8 constants
    localparam logic [15:0] ZERO = 16'h0000;
    localparam logic [15:0] ONE  = 16'h0100;
    localparam logic [15:0] MONE = 16'hFF00;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [afc_pkg::ROW_W-1:0]     model_row0 = '0, model_row1 = '0;
    logic [afc_pkg::ROW_W-1:0]     model_row2 = '0, model_row3 = '0;
    logic [afc_pkg::VEC_W-1:0]     box_min = '0, box_max = '0;
    logic                          done;
    logic                          visible;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [afc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [afc_pkg::ROW_W-1:0]     cfg_data = '0;

    int fail_cnt, pending, n_visible, n_culled;
    int n_items = 0;
    int n_writes = 0;
    int idle_cnt = 0;
    bit no_gaps = 0;

    always #5 clk = ~clk;

    aabb_frustum_cull dut (.*);

    afc_checker chk (.*);

    // Watchdog on cycles with no traffic
    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else if (rst_n)
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT)
        begin
            $display("watchdog: no traffic for %0d cycles", WD_LIMIT);
            $display("FAIL aabb_frustum_cull");
            $finish;
        end
    end

    function automatic logic [afc_pkg::ROW_W-1:0] row4(input logic [15:0] c0, c1, c2, c3);
        return {c3, c2, c1, c0};
    endfunction

    function automatic logic [afc_pkg::VEC_W-1:0] vec3(input logic [15:0] x, y, z);
        return {z, y, x};
    endfunction

    // Small Q8.8 value in +-range/256
    function automatic logic [15:0] small_q(input int range);
        return 16'($signed($urandom_range(0, 2 * range)) - range);
    endfunction

    // Random burst of idle cycles on the item side
    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(0, 5) == 0)
        begin
            start = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clk);
        end
    endtask

    // Present one item at a falling edge and hold until taken
    task automatic send_item(input logic [afc_pkg::ROW_W-1:0] m0, m1, m2, m3,
                             input logic [afc_pkg::VEC_W-1:0] bmin, bmax);
        logic b;
        maybe_gap();
        model_row0 = m0;
        model_row1 = m1;
        model_row2 = m2;
        model_row3 = m3;
        box_min = bmin;
        box_max = bmax;
        start = 1'b1;
        do
        begin
            b = busy;
            @(posedge clk);
        end
        while (b);
        n_items++;
        @(negedge clk);
    endtask

    // Register write, only once the pipeline has drained
    task automatic write_reg(input logic [afc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [afc_pkg::ROW_W-1:0] val);
        logic r;
        start = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        cfg_index = idx;
        cfg_data = val;
        cfg_valid = 1'b1;
        do
        begin
            r = cfg_ready;
            @(posedge clk);
        end
        while (!r);
        n_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_vp(input logic [afc_pkg::ROW_W-1:0] r0, r1, r2, r3);
        write_reg(afc_pkg::REG_VP_ROW0, r0);
        write_reg(afc_pkg::REG_VP_ROW1, r1);
        write_reg(afc_pkg::REG_VP_ROW2, r2);
        write_reg(afc_pkg::REG_VP_ROW3, r3);
    endtask

    // Mostly near-identity model and small boxes near the frustum, some noise
    task automatic rand_item();
        logic [15:0] t [3];
        int          sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            for (int a = 0; a < 3; a++)
                t[a] = small_q(768);
            send_item(row4(ONE + small_q(64), small_q(64), small_q(64), t[0]),
                      row4(small_q(64), ONE + small_q(64), small_q(64), t[1]),
                      row4(small_q(64), small_q(64), ONE + small_q(64), t[2]),
                      row4(small_q(8), small_q(8), small_q(8), ONE + small_q(8)),
                      vec3(small_q(200), small_q(200), small_q(200)),
                      vec3(small_q(200), small_q(200), small_q(200)));
        end
        else
        begin
            send_item({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom},
                      afc_pkg::VEC_W'({$urandom, $urandom}),
                      afc_pkg::VEC_W'({$urandom, $urandom}));
        end
    endtask

    // Random view-projection near an ortho box, scaled
    task automatic rand_vp();
        write_vp(row4(small_q(512), small_q(64), small_q(64), small_q(256)),
                 row4(small_q(64), small_q(512), small_q(64), small_q(256)),
                 row4(small_q(64), small_q(64), small_q(512), small_q(256)),
                 row4(small_q(32), small_q(32), small_q(32), small_q(512)));
    endtask

    logic [afc_pkg::ROW_W-1:0] id0, id1, id2, id3;

    initial
    begin
        id0 = row4(ONE, ZERO, ZERO, ZERO);
        id1 = row4(ZERO, ONE, ZERO, ZERO);
        id2 = row4(ZERO, ZERO, ONE, ZERO);
        id3 = row4(ZERO, ZERO, ZERO, ONE);
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset matrix: every plane zero, so everything is visible
        send_item(id0, id1, id2, row4(ZERO, ZERO, ZERO, 16'h7FFF),
                  vec3(ZERO, ZERO, ZERO), vec3(ZERO, ZERO, ZERO));
        send_item({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}},
                  {3{16'h8000}}, {3{16'h7FFF}});

        // Unit ortho frustum: |x|,|y|,|z| <= w
        write_vp(id0, id1, id2, id3);
        send_item(id0, id1, id2, id3, vec3(MONE, MONE, MONE), vec3(ONE, ONE, ONE));
        // translated far along +x, then -y: culled
        send_item(row4(ONE, ZERO, ZERO, 16'h0A00), id1, id2, id3,
                  vec3(ZERO, ZERO, ZERO), vec3(ONE, ONE, ONE));
        send_item(id0, row4(ZERO, ONE, ZERO, 16'hF600), id2, id3,
                  vec3(ZERO, ZERO, ZERO), vec3(ONE, ONE, ONE));
        // box touching x = 1 exactly: dot product zero counts as inside
        send_item(id0, id1, id2, id3, vec3(ONE, ZERO, ZERO), vec3(16'h0200, ONE, ONE));
        // just beyond x = 1: culled
        send_item(id0, id1, id2, id3, vec3(16'h0101, ZERO, ZERO), vec3(16'h0200, ONE, ONE));
        // minimum above maximum, inside and outside
        send_item(id0, id1, id2, id3, vec3(ONE, ONE, ONE), vec3(MONE, MONE, MONE));
        send_item(id0, id1, id2, id3, vec3(16'h0500, ZERO, ZERO), vec3(16'h0300, ZERO, ZERO));
        // field extremes
        send_item('0, '0, '0, '0, '0, '0);
        send_item('1, '1, '1, '1, '1, '1);
        send_item({4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}}, {4{16'h7FFF}},
                  {3{16'h7FFF}}, {3{16'h8000}});
        send_item({4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}},
                  {3{16'h8000}}, {3{16'h8000}});
        send_item(id0, id1, id2, row4(ZERO, ZERO, ZERO, 16'h8000),
                  vec3(MONE, MONE, MONE), vec3(ONE, ONE, ONE));
        // writes beyond the last register are ignored
        write_reg(4'd4, '1);
        write_reg(4'd15, {$urandom, $urandom});
        send_item(id0, id1, id2, id3, vec3(MONE, MONE, MONE), vec3(ONE, ONE, ONE));

        // Random phases over several frustum settings, extremes included
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: write_vp(id0, id1, id2, id3);
                1: write_vp({4{16'h7FFF}}, {4{16'h8000}}, {4{16'h7FFF}}, {4{16'h8000}});
                2: write_vp('1, '1, '1, '1);
                3: write_vp({$urandom, $urandom}, {$urandom, $urandom},
                            {$urandom, $urandom}, {$urandom, $urandom});
                4: write_reg(4'($urandom_range(4, 15)), {$urandom, $urandom});
                default: rand_vp();
            endcase
            no_gaps = (ph == 6);
            for (int i = 0; i < RAND_ITEMS / 7; i++)
                rand_item();
        end
        start = 1'b0;

        // Drain and let the pipeline settle
        while (pending != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);

        $display("Sent %0d items over %0d register writes and several frustum settings;",
                 n_items, n_writes);
        $display("results: %0d visible, %0d culled, %0d outstanding",
                 n_visible, n_culled, pending);
        if (fail_cnt == 0 && pending == 0)
            $display("PASS aabb_frustum_cull");
        else
            $display("FAIL aabb_frustum_cull");
        $finish;
    end

endmodule

### sim.f
design/afc_pkg.sv
design/afc_corner_xform.sv
design/aabb_frustum_cull.sv
sim/afc_checker.sv
sim/aabb_frustum_cull_tb.sv
